>>> rtl/core/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg
// Types and constants shared by the trie prefix match table.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int ALPHABET  = 256;
  localparam int MAX_NODES = 1024;

  localparam int SYM_W   = $clog2(ALPHABET);
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int SLOT_W  = NODE_W + SYM_W;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
    logic [7:0] insert_mode;
  } tpm_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] mode_value;
  } tpm_rsp_t;

  // one entry of the per-node memory
  typedef struct packed {
    logic       leaf;
    logic [7:0] mode;
  } tpm_node_t;

endpackage

>>> rtl/core/trie_prefix_match_table.sv
// ----------------------------------------------------------------------------
// trie_prefix_match_table
// Character trie held in a child pointer memory and a per-node memory,
// walked one character per request; insert appends nodes, lookup returns the
// mode of the first leaf met (prefix match).
// ----------------------------------------------------------------------------
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+-----------------------------
//   request | req_valid  | req_stall  | req  (tpm_req_t, in)
//   result  | rsp_valid  | rsp_stall  | rsp  (tpm_rsp_t, out)
//
// A character request, until the walk is decided, reads the child pointer for
// the current node when accepted, then takes the walk step that updates the node.
// A closing request adds the S_FINAL step, which uses the node memory read of the
// final node; a request with no character and not closing is done in S_IDLE alone.
// After reset the child memory is cleared one entry per cycle (MAX_NODES*ALPHABET
// entries, 262144), the per-node memory alongside, with req_stall high throughout.
// A waiting result sits in the output register; the next closing request
// holds in S_FINAL until that register is free.
module trie_prefix_match_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tpm_pkg::tpm_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tpm_pkg::tpm_rsp_t rsp
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;

  localparam int NODE_W = tpm_pkg::NODE_W;
  localparam int SYM_W  = tpm_pkg::SYM_W;
  localparam int SLOT_W = tpm_pkg::SLOT_W;
  localparam int CNT_W  = tpm_pkg::CNT_W;

  logic [2:0] state, state_next;

  // memories
  logic [NODE_W-1:0]      child_mem [0:(2**SLOT_W)-1];
  tpm_pkg::tpm_node_t     node_mem  [0:(2**NODE_W)-1];
  logic [NODE_W-1:0]      child_rd;
  tpm_pkg::tpm_node_t     node_rd;

  logic                   child_we;
  logic [SLOT_W-1:0]      child_wa;
  logic [NODE_W-1:0]      child_wd;
  logic [SLOT_W-1:0]      child_ra;
  logic                   node_we;
  logic [NODE_W-1:0]      node_wa;
  tpm_pkg::tpm_node_t     node_wd;

  // walk state
  logic [SLOT_W-1:0]      clr, clr_next;
  logic [NODE_W-1:0]      cur, cur_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   decided, decided_next;
  logic [1:0]             dstatus, dstatus_next;
  logic [7:0]             dmode, dmode_next;

  // held request
  tpm_pkg::tpm_req_t      item;
  logic [SLOT_W-1:0]      slot;

  logic                   rsp_load;
  tpm_pkg::tpm_rsp_t      rsp_next;

  logic                   accept;
  logic [SYM_W-1:0]       sym;
  logic                   out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // characters beyond the alphabet saturate to the last symbol
  always_comb begin
    if (int'(req.char_code) >= tpm_pkg::ALPHABET) begin
      sym = SYM_W'(tpm_pkg::ALPHABET - 1);
    end else begin
      sym = req.char_code[SYM_W-1:0];
    end
  end

  assign child_ra = {cur, sym};

  always_comb begin
    state_next   = state;
    clr_next     = clr;
    cur_next     = cur;
    count_next   = count;
    decided_next = decided;
    dstatus_next = dstatus;
    dmode_next   = dmode;
    child_we     = 1'b0;
    child_wa     = slot;
    child_wd     = count[NODE_W-1:0];
    node_we      = 1'b0;
    node_wa      = count[NODE_W-1:0];
    node_wd      = '{leaf: 1'b0, mode: 8'd1};
    rsp_load     = 1'b0;
    rsp_next     = '{status: tpm_pkg::ST_OK, mode_value: 8'd0};

    unique case (state)
      S_CLEAR: begin
        child_we = 1'b1;
        child_wa = clr;
        child_wd = '0;
        node_we  = 1'b1;
        node_wa  = clr[NODE_W-1:0];
        clr_next = clr + 1'b1;
        if (&clr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req.has_char && !decided) begin
            state_next = S_WALK;
          end else if (req.last_char) begin
            state_next = S_FINAL;
          end
        end
      end
      S_WALK: begin
        if (item.cmd == tpm_pkg::CMD_INSERT) begin
          if (child_rd == '0) begin
            if (int'(count) >= tpm_pkg::MAX_NODES) begin
              decided_next = 1'b1;
              dstatus_next = tpm_pkg::ST_FULL;
              dmode_next   = 8'd0;
            end else begin
              child_we   = 1'b1;
              node_we    = 1'b1;
              count_next = count + 1'b1;
              cur_next   = count[NODE_W-1:0];
            end
          end else begin
            cur_next = child_rd;
          end
        end else begin
          if (node_rd.leaf) begin
            decided_next = 1'b1;
            dstatus_next = tpm_pkg::ST_OK;
            dmode_next   = node_rd.mode;
          end else if (child_rd == '0) begin
            decided_next = 1'b1;
            dstatus_next = tpm_pkg::ST_NOT_FOUND;
            dmode_next   = 8'd0;
          end else begin
            cur_next = child_rd;
          end
        end
        state_next = item.last_char ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        if (out_free) begin
          rsp_load = 1'b1;
          if (decided) begin
            rsp_next = '{status: dstatus, mode_value: dmode};
          end else if (item.cmd == tpm_pkg::CMD_INSERT) begin
            node_we = 1'b1;
            node_wa = cur;
            node_wd = '{leaf: 1'b1, mode: item.insert_mode};
          end else if (cur == '0) begin
            rsp_next = '{status: tpm_pkg::ST_OK, mode_value: 8'd0};
          end else if (node_rd.leaf) begin
            rsp_next = '{status: tpm_pkg::ST_OK, mode_value: node_rd.mode};
          end else begin
            rsp_next = '{status: tpm_pkg::ST_NOT_FOUND, mode_value: 8'd0};
          end
          cur_next     = '0;
          decided_next = 1'b0;
          dstatus_next = tpm_pkg::ST_OK;
          dmode_next   = 8'd0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // child pointer memory
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    child_rd <= child_mem[child_ra];
  end

  // per-node memory; read follows the node the walk moves to
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_rd <= node_mem[cur_next];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
      slot <= child_ra;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cur       <= '0;
      count     <= CNT_W'(1);
      decided   <= 1'b0;
      dstatus   <= tpm_pkg::ST_OK;
      dmode     <= 8'd0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr     <= clr_next;
      cur     <= cur_next;
      count   <= count_next;
      decided <= decided_next;
      dstatus <= dstatus_next;
      dmode   <= dmode_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
